>>> hw/rtl/xorshift128_random_source_unit_defines.svh
// Assertion helpers shared by the RTL of the random source.
// Each expects clk and rst_n in scope at the point of use.
`ifndef XORSHIFT128_RANDOM_SOURCE_UNIT_DEFINES_SVH
`define XORSHIFT128_RANDOM_SOURCE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define XSRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define XSRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/xsrs_pkg.sv
package xsrs_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned VALUE_W  = 33;
    localparam int unsigned OPCODE_W = 3;

    // Request opcodes
    localparam logic [OPCODE_W-1:0] OP_WORD32  = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_VALUE31 = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_BELOW   = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_RANGE   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_BIT     = 3'd4;

    // Start values of the upper three state words
    localparam logic [WORD_W-1:0] Y_START = 32'd842502087;
    localparam logic [WORD_W-1:0] Z_START = 32'd3579807591;
    localparam logic [WORD_W-1:0] W_START = 32'd273326509;

    // Bit buffer fill mark: 32 used means empty
    localparam logic [5:0] BITS_EMPTY = 6'd32;

    // What the back end has to do with a queued item
    typedef enum logic [2:0] {
        KIND_WORD32,
        KIND_VALUE31,
        KIND_BELOW,
        KIND_RANGE,
        KIND_BIT,
        KIND_NONE
    } kind_t;

    // One queued item: class, raw draw (or the bit in bit 0) and the bounds
    typedef struct packed {
        kind_t              kind;
        logic [WORD_W-1:0]  data;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
    } item_t;

    // Queue status seen by the front and back ends
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> hw/rtl/xsrs_front.sv
module xsrs_front (
    input  logic                              clk,
    input  logic                              rst_n,
    // seed register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic signed [31:0]                seed,
    // request side
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [xsrs_pkg::OPCODE_W-1:0]     opcode,
    input  logic signed [31:0]                lower_bound,
    input  logic signed [31:0]                upper_bound,
    // queue side
    input  xsrs_pkg::q_status_t               q_status,
    output logic                              push,
    output xsrs_pkg::item_t                   push_item
);

    localparam int unsigned SHIFT_T  = 11;
    localparam int unsigned SHIFT_W  = 19;
    localparam int unsigned SHIFT_TT = 8;

    logic [31:0] word_x_reg, word_x_next;
    logic [31:0] word_y_reg, word_y_next;
    logic [31:0] word_z_reg, word_z_next;
    logic [31:0] word_w_reg, word_w_next;
    logic [31:0] bit_store_reg, bit_store_next;
    logic [5:0]  bits_used_reg, bits_used_next;
    logic [31:0] t_mix;
    logic [31:0] draw_val;
    logic        do_draw;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_status.full;
    assign push      = in_valid && !q_status.full;

    // One xorshift128 step from the current words
    always_comb
    begin
        t_mix    = word_x_reg ^ (word_x_reg << SHIFT_T);
        draw_val = word_w_reg ^ (word_w_reg >> SHIFT_W) ^ t_mix ^ (t_mix >> SHIFT_TT);
    end

    // Classify the request and work out the next generator state
    always_comb
    begin
        do_draw                 = 1'b0;
        bit_store_next          = bit_store_reg;
        bits_used_next          = bits_used_reg;
        push_item.kind          = xsrs_pkg::KIND_NONE;
        push_item.data          = draw_val;
        push_item.lower_bound   = lower_bound;
        push_item.upper_bound   = upper_bound;
        case (opcode)
            xsrs_pkg::OP_WORD32:
            begin
                do_draw        = push;
                push_item.kind = xsrs_pkg::KIND_WORD32;
            end
            xsrs_pkg::OP_VALUE31:
            begin
                do_draw        = push;
                push_item.kind = xsrs_pkg::KIND_VALUE31;
            end
            xsrs_pkg::OP_BELOW:
            begin
                do_draw        = push;
                push_item.kind = xsrs_pkg::KIND_BELOW;
            end
            xsrs_pkg::OP_RANGE:
            begin
                do_draw        = push;
                push_item.kind = xsrs_pkg::KIND_RANGE;
            end
            xsrs_pkg::OP_BIT:
            begin
                push_item.kind = xsrs_pkg::KIND_BIT;
                if (bits_used_reg[5])
                begin
                    // buffer empty: refill from a fresh draw
                    do_draw        = push;
                    push_item.data = {31'd0, draw_val[0]};
                    if (push)
                    begin
                        bit_store_next = draw_val;
                        bits_used_next = 6'd1;
                    end
                end
                else
                begin
                    push_item.data = {31'd0, bit_store_reg[1]};
                    if (push)
                    begin
                        bit_store_next = bit_store_reg >> 1;
                        bits_used_next = bits_used_reg + 6'd1;
                    end
                end
            end
            default:
            begin
                push_item.kind = xsrs_pkg::KIND_NONE;
            end
        endcase

        word_x_next = word_x_reg;
        word_y_next = word_y_reg;
        word_z_next = word_z_reg;
        word_w_next = word_w_reg;
        if (do_draw)
        begin
            word_x_next = word_y_reg;
            word_y_next = word_z_reg;
            word_z_next = word_w_reg;
            word_w_next = draw_val;
        end
        // seed write reseeds the generator and empties the bit buffer
        if (cfg_valid)
        begin
            word_x_next    = seed;
            word_y_next    = xsrs_pkg::Y_START;
            word_z_next    = xsrs_pkg::Z_START;
            word_w_next    = xsrs_pkg::W_START;
            bits_used_next = xsrs_pkg::BITS_EMPTY;
        end
    end

    // Generator words and buffer fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_x_reg    <= '0;
            word_y_reg    <= xsrs_pkg::Y_START;
            word_z_reg    <= xsrs_pkg::Z_START;
            word_w_reg    <= xsrs_pkg::W_START;
            bits_used_reg <= xsrs_pkg::BITS_EMPTY;
        end
        else
        begin
            word_x_reg    <= word_x_next;
            word_y_reg    <= word_y_next;
            word_z_reg    <= word_z_next;
            word_w_reg    <= word_w_next;
            bits_used_reg <= bits_used_next;
        end
    end

    // Bit buffer payload, read only after a refill
    always_ff @(posedge clk)
    begin
        bit_store_reg <= bit_store_next;
    end

endmodule

>>> hw/rtl/xsrs_queue.sv
`include "xorshift128_random_source_unit_defines.svh"

module xsrs_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  xsrs_pkg::item_t      push_item,
    input  logic                 pop,
    output xsrs_pkg::item_t      head_item,
    output xsrs_pkg::q_status_t  q_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    xsrs_pkg::item_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head_item      = slot_reg[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `XSRS_ASSERT_NOW(a_q_no_overflow, push, !q_status.full || pop, "queue written while full")
    `XSRS_ASSERT_NOW(a_q_no_underflow, pop, !q_status.empty, "queue read while empty")
    `XSRS_ASSERT_NEXT(a_q_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "count did not rise on write")

endmodule

>>> hw/rtl/xsrs_back.sv
`include "xorshift128_random_source_unit_defines.svh"

module xsrs_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  xsrs_pkg::q_status_t               q_status,
    input  xsrs_pkg::item_t                   head_item,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [xsrs_pkg::VALUE_W-1:0]      value
);

    logic                  advance;
    logic signed [31:0]    mul_a;
    logic signed [32:0]    range_diff;
    logic signed [32:0]    mul_b;
    logic signed [64:0]    product;
    logic signed [31:0]    base_lower;

    xsrs_pkg::kind_t       s1_kind_reg;
    logic [31:0]           s1_data_reg;
    logic signed [64:0]    s1_prod_reg;
    logic signed [31:0]    s1_lower_reg;
    logic                  s1_valid_reg, s1_valid_next;

    logic signed [65:0]    sum;
    logic [34:0]           quot;
    logic [xsrs_pkg::VALUE_W-1:0] out_value_next;
    logic [xsrs_pkg::VALUE_W-1:0] out_value_reg;
    logic                  out_valid_reg, out_valid_next;

    // Whole back end moves when the output register is free or being taken
    assign advance   = !out_valid_reg || out_ready;
    assign pop       = advance && !q_status.empty;
    assign out_valid = out_valid_reg;
    assign value     = out_value_reg;

    // Stage 1: scale the 31-bit fraction by the bound or the bound span
    always_comb
    begin
        mul_a      = $signed({1'b0, head_item.data[30:0]});
        range_diff = 33'(head_item.upper_bound) - 33'(head_item.lower_bound);
        if (head_item.kind == xsrs_pkg::KIND_RANGE)
        begin
            mul_b      = range_diff;
            base_lower = head_item.lower_bound;
        end
        else
        begin
            mul_b      = 33'(head_item.upper_bound);
            base_lower = '0;
        end
        product = 65'(mul_a) * 65'(mul_b);
    end

    // Stage 2: add the lower base, divide by 2^31 rounding toward zero
    always_comb
    begin
        sum  = 66'(s1_prod_reg) + {{3{s1_lower_reg[31]}}, s1_lower_reg, 31'd0};
        quot = sum[65:31] + 35'(sum[65] && (sum[30:0] != '0));
        case (s1_kind_reg)
            xsrs_pkg::KIND_WORD32:  out_value_next = {1'b0, s1_data_reg};
            xsrs_pkg::KIND_VALUE31: out_value_next = {2'b00, s1_data_reg[30:0]};
            xsrs_pkg::KIND_BELOW:   out_value_next = quot[32:0];
            xsrs_pkg::KIND_RANGE:   out_value_next = quot[32:0];
            xsrs_pkg::KIND_BIT:     out_value_next = {32'd0, s1_data_reg[0]};
            default:                out_value_next = '0;
        endcase
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            s1_valid_next  = pop;
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers of both stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kind_reg   <= head_item.kind;
            s1_data_reg   <= head_item.data;
            s1_prod_reg   <= product;
            s1_lower_reg  <= base_lower;
            out_value_reg <= out_value_next;
        end
    end

    `XSRS_ASSERT_NEXT(a_back_pop_lands, pop, s1_valid_reg, "popped item missing from stage 1")
    `XSRS_ASSERT_NEXT(a_back_s1_holds, s1_valid_reg && !advance, s1_valid_reg, "stage 1 item lost in stall")
    `XSRS_ASSERT_NEXT(a_back_s1_moves, s1_valid_reg && advance, out_valid_reg, "stage 1 item not moved to output")

endmodule

>>> hw/rtl/xorshift128_random_source_unit.sv
// Registers on a request's path: queue slot, stage 1 (multiply), output register (sum).
// Throughput: one request per cycle unless the queue is full or m_axis_tready holds the output.
// Bit requests draw from the generator once every 32 requests; other opcodes 0-3 draw each time.
// Reset (rst_n low, asynchronous): seed 0, state words at their start values, bit buffer empty,
// queue and pipeline empty. A seed write reseeds the same way, keeping queued results.
module xorshift128_random_source_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    // seed register write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    // requests
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // [2:0] opcode, [34:3] lower_bound, [66:35] upper_bound
    // results
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [39:0]  m_axis_tdata   // [32:0] value
);

    xsrs_pkg::q_status_t            q_status;
    xsrs_pkg::item_t                push_item;
    xsrs_pkg::item_t                head_item;
    logic                           push;
    logic                           pop;
    logic [xsrs_pkg::VALUE_W-1:0]   value;

    // Front end: generator state and request classification
    xsrs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .seed        ($signed(cfg_data)),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .opcode      (s_axis_tdata[2:0]),
        .lower_bound ($signed(s_axis_tdata[34:3])),
        .upper_bound ($signed(s_axis_tdata[66:35])),
        .q_status    (q_status),
        .push        (push),
        .push_item   (push_item)
    );

    // Decoupling queue
    xsrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .q_status  (q_status)
    );

    // Back end: scaling pipeline and output register
    xsrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head_item (head_item),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .value     (value)
    );

    assign m_axis_tdata = {7'd0, value};

endmodule
